// ----- src/mite_pkg.sv -----
// Shared opcodes, register codes and stage types of the I-type execute block.
`default_nettype none

package mite_pkg;

    localparam int DATA_WORDS_DEFAULT = 1024;

    // Primary opcodes, instruction bits 31..26.
    localparam logic [5:0] OP_REGIMM = 6'h01;
    localparam logic [5:0] OP_BEQ    = 6'h04;
    localparam logic [5:0] OP_BNE    = 6'h05;
    localparam logic [5:0] OP_BLEZ   = 6'h06;
    localparam logic [5:0] OP_BGTZ   = 6'h07;
    localparam logic [5:0] OP_ADDI   = 6'h08;
    localparam logic [5:0] OP_ADDI_U = 6'h09;
    localparam logic [5:0] OP_SLTI   = 6'h0A;
    localparam logic [5:0] OP_SLTI_U = 6'h0B;
    localparam logic [5:0] OP_ANDI   = 6'h0C;
    localparam logic [5:0] OP_ORI    = 6'h0D;
    localparam logic [5:0] OP_XORI   = 6'h0E;
    localparam logic [5:0] OP_LUI    = 6'h0F;
    localparam logic [5:0] OP_LB     = 6'h20;
    localparam logic [5:0] OP_LW     = 6'h23;
    localparam logic [5:0] OP_SB     = 6'h28;
    localparam logic [5:0] OP_SW     = 6'h2B;

    // Branch codes carried in the rt field of the REGIMM group.
    localparam logic [4:0] RT_BLTZ   = 5'd0;
    localparam logic [4:0] RT_BGEZ   = 5'd1;
    localparam logic [4:0] RT_BLTZAL = 5'd16;
    localparam logic [4:0] RT_BGEZAL = 5'd17;

    localparam logic [4:0] REG_ZERO = 5'd0;
    localparam logic [4:0] REG_LINK = 5'd31;

    // Outcome of the execute stage, carried down the memory pipeline.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        taken;
        logic        unimpl;
        logic        wr;
        logic [4:0]  widx;
        logic [31:0] wval;
        logic        load;
        logic        store;
        logic        byte_acc;
        logic [31:0] maddr;
        logic [31:0] mdata;
    } t_exec;

    // One result beat as it leaves the block.
    typedef struct packed {
        logic [31:0] next_pc;
        logic        br_taken;
        logic        reg_write;
        logic [4:0]  reg_index;
        logic [31:0] reg_value;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_data;
        logic        byte_access;
        logic        unimplemented;
    } t_result;

    typedef struct packed {
        logic        en;
        logic [4:0]  idx;
        logic [31:0] data;
    } t_rf_write;

endpackage

`default_nettype wire

// ----- src/mite_regfile.sv -----
// General register file: 32 words, two registered read ports, one write port.
`default_nettype none

module mite_regfile (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [4:0]           i_raddr_a,
    input  wire logic [4:0]           i_raddr_b,
    input  wire mite_pkg::t_rf_write  i_wr,
    output logic [31:0]               o_rdata_a,
    output logic [31:0]               o_rdata_b
);
    import mite_pkg::*;

    logic [31:0] r_mem [32];
    logic [31:0] r_valid;
    logic [31:0] r_rd_a;
    logic [31:0] r_rd_b;
    logic        r_vld_a;
    logic        r_vld_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            r_vld_a <= r_valid[i_raddr_a];
            r_vld_b <= r_valid[i_raddr_b];
        end
    end

    assign o_rdata_a = r_vld_a ? r_rd_a : '0;
    assign o_rdata_b = r_vld_b ? r_rd_b : '0;

endmodule

`default_nettype wire

// ----- src/mite_dmem.sv -----
// Word data memory with one registered read port, one write port and a clearing sweep.
`default_nettype none

module mite_dmem #(
    parameter  int DATA_WORDS = mite_pkg::DATA_WORDS_DEFAULT,
    localparam int IDX_W      = $clog2(DATA_WORDS)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [31:0]      i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic [31:0]           o_rdata,
    output logic                  o_clearing
);
    import mite_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_WORDS - 1);

    logic [31:0]      r_mem [DATA_WORDS];
    logic [31:0]      r_rdata;
    logic [IDX_W-1:0] r_clr_idx;
    logic             r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

// ----- src/mite_alu.sv -----
// Execute stage: decode, branch resolution, immediate arithmetic and address generation.
`default_nettype none

module mite_alu (
    input  wire logic [31:0] i_instr,
    input  wire logic [31:0] i_pc,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output mite_pkg::t_exec  o_exec
);
    import mite_pkg::*;

    logic [5:0]  op;
    logic [4:0]  rt;
    logic [15:0] imm;
    logic [31:0] sext;
    logic [31:0] zext;
    logic [31:0] sum;
    logic        a_neg;
    logic        link;
    t_exec       ex;

    assign op    = i_instr[31:26];
    assign rt    = i_instr[20:16];
    assign imm   = i_instr[15:0];
    assign sext  = {{16{imm[15]}}, imm};
    assign zext  = {16'b0, imm};
    assign sum   = i_a + sext;
    assign a_neg = i_a[31];

    always_comb begin
        ex         = '0;
        ex.next_pc = i_pc + 32'd4;
        ex.widx    = rt;
        link       = 1'b0;
        case (op)
            OP_REGIMM: begin
                case (rt)
                    RT_BLTZ, RT_BLTZAL: ex.taken  = a_neg;
                    RT_BGEZ, RT_BGEZAL: ex.taken  = !a_neg;
                    default:            ex.unimpl = 1'b1;
                endcase
                link = rt[4];
            end
            OP_BEQ:  ex.taken = (i_a == i_b);
            OP_BNE:  ex.taken = (i_a != i_b);
            OP_BLEZ: ex.taken = a_neg || (i_a == '0);
            OP_BGTZ: ex.taken = !a_neg && (i_a != '0);
            OP_ADDI, OP_ADDI_U: begin
                ex.wr   = 1'b1;
                ex.wval = sum;
            end
            OP_SLTI: begin
                ex.wr   = 1'b1;
                ex.wval = {31'b0, $signed(i_a) < $signed(sext)};
            end
            OP_SLTI_U: begin
                ex.wr   = 1'b1;
                ex.wval = {31'b0, i_a < sext};
            end
            OP_ANDI: begin
                ex.wr   = 1'b1;
                ex.wval = i_a & zext;
            end
            OP_ORI: begin
                ex.wr   = 1'b1;
                ex.wval = i_a | zext;
            end
            OP_XORI: begin
                ex.wr   = 1'b1;
                ex.wval = i_a ^ zext;
            end
            OP_LUI: begin
                ex.wr   = 1'b1;
                ex.wval = {imm, 16'b0};
            end
            OP_LB: begin
                ex.wr       = 1'b1;
                ex.load     = 1'b1;
                ex.byte_acc = 1'b1;
                ex.maddr    = sum;
            end
            OP_LW: begin
                ex.wr    = 1'b1;
                ex.load  = 1'b1;
                ex.maddr = sum;
            end
            OP_SB: begin
                ex.store    = 1'b1;
                ex.byte_acc = 1'b1;
                ex.maddr    = sum;
                ex.mdata    = {24'b0, i_b[7:0]};
            end
            OP_SW: begin
                ex.store = 1'b1;
                ex.maddr = sum;
                ex.mdata = i_b;
            end
            default: ex.unimpl = 1'b1;
        endcase

        if (ex.unimpl) begin
            // Unsupported words leave every piece of state as it was.
            ex         = '0;
            ex.unimpl  = 1'b1;
            ex.next_pc = i_pc;
        end else begin
            if (ex.taken) begin
                ex.next_pc = i_pc + 32'd4 + {sext[29:0], 2'b00};
                if (link) begin
                    ex.wr   = 1'b1;
                    ex.widx = REG_LINK;
                    ex.wval = i_pc + 32'd8;
                end
            end
            if (ex.wr && ex.widx == REG_ZERO) begin
                ex.wr = 1'b0;
            end
            if (!ex.wr) begin
                ex.widx = REG_ZERO;
                ex.wval = '0;
            end
        end
    end

    assign o_exec = ex;

endmodule

`default_nettype wire

// ----- src/mips_itype_execute.sv -----
// Top level of the I-type execute block: pipeline, forwarding, memory index and output skid.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------------
//  config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_data (reset_pc)
//  instr    | in        | i_in_valid  / o_in_ready  | i_instruction
//  result   | out       | o_out_valid / i_out_ready | o_next_pc ... o_unimplemented
//
// One instruction is taken per cycle while no load hazard, memory sweep or full output buffer
// holds the input. Stages: execute, two stages that reduce the word address modulo DATA_WORDS,
// then the data memory read and commit, whose result beat is registered in the output buffer.
// An instruction that reads the target of a load in either index stage waits in execute
// until the load commits. After reset the data memory is swept to zero with o_in_ready low;
// configuration is always ready. A two-entry output buffer keeps one more beat while the
// consumer stalls, and the whole pipeline holds once that buffer is full.
`default_nettype none

module mips_itype_execute #(
    parameter int DATA_WORDS = mite_pkg::DATA_WORDS_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_instruction,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_next_pc,
    output logic             o_br_taken,
    output logic             o_reg_write,
    output logic [4:0]       o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic             o_mem_write,
    output logic [31:0]      o_mem_address,
    output logic [31:0]      o_mem_data,
    output logic             o_byte_access,
    output logic             o_unimplemented
);
    import mite_pkg::*;

    localparam int IDX_W = $clog2(DATA_WORDS);
    localparam int SHIFT = 30 + IDX_W;
    // Reciprocal of DATA_WORDS, exact for every 30-bit word address.
    localparam logic [63:0] MAGIC_WIDE =
        ((64'd1 << SHIFT) + 64'(DATA_WORDS) - 64'd1) / 64'(DATA_WORDS);
    localparam logic [31:0] MAGIC = MAGIC_WIDE[31:0];

    // Stage registers.
    logic             r_s1_valid;
    logic [31:0]      r_s1_instr;
    logic             r_s2_valid;
    t_exec            r_s2;
    logic             r_s3_valid;
    t_exec            r_s3;
    logic [29:0]      r_s3_quot;
    logic             r_s4_valid;
    t_exec            r_s4;
    logic [IDX_W-1:0] r_s4_idx;
    logic [31:0]      r_pc;

    // Last committed writes, for reads issued on the same edge.
    logic             r_wb_valid;
    logic [4:0]       r_wb_idx;
    logic [31:0]      r_wb_val;
    logic             r_st_valid;
    logic [IDX_W-1:0] r_st_idx;
    logic [31:0]      r_st_word;

    // Output buffer.
    logic             r_out_valid;
    t_result          r_out;
    logic             r_skid_valid;
    t_result          r_skid;

    logic             adv;
    logic             hz;
    logic             in_accept;
    logic             commit;
    logic             pop;
    logic             clearing;
    logic [4:0]       s1_rs;
    logic [4:0]       s1_rt;
    logic [4:0]       rf_raddr_a;
    logic [4:0]       rf_raddr_b;
    logic [31:0]      rf_a;
    logic [31:0]      rf_b;
    logic [31:0]      op_a;
    logic [31:0]      op_b;
    t_exec            s1_exec;
    logic [61:0]      s2_prod;
    logic [29:0]      s2_quot;
    logic [29:0]      s3_word;
    logic [29:0]      s3_rem;
    logic [IDX_W-1:0] s3_idx;
    logic [IDX_W-1:0] dm_raddr;
    logic [31:0]      dm_rdata;
    logic [31:0]      s4_word;
    logic [1:0]       s4_lane;
    logic [7:0]       s4_byte;
    logic [31:0]      s4_load_val;
    logic [31:0]      s4_wval;
    logic [31:0]      s4_merged;
    t_result          s4_res;
    t_rf_write        rf_wr;
    logic             dm_we;

    // The pipeline moves as long as the output buffer has room.
    assign adv       = !r_skid_valid;
    assign commit    = adv && r_s4_valid;
    assign pop       = r_out_valid && i_out_ready;
    assign s1_rs     = r_s1_instr[25:21];
    assign s1_rt     = r_s1_instr[20:16];

    // A load's value exists only at commit, so a reader waits while the load is in
    // either index stage.
    assign hz = r_s1_valid && (
        (r_s2_valid && r_s2.load && r_s2.wr && (r_s2.widx == s1_rs || r_s2.widx == s1_rt)) ||
        (r_s3_valid && r_s3.load && r_s3.wr && (r_s3.widx == s1_rs || r_s3.widx == s1_rt)));

    assign o_in_ready  = adv && !clearing && !hz;
    assign in_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // The register file is read every cycle for whatever sits in execute next.
    assign rf_raddr_a = in_accept ? i_instruction[25:21] : s1_rs;
    assign rf_raddr_b = in_accept ? i_instruction[20:16] : s1_rt;

    mite_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_raddr_a (rf_raddr_a),
        .i_raddr_b (rf_raddr_b),
        .i_wr      (rf_wr),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    // Youngest producer wins: index stages, commit stage, last committed write, file.
    function automatic logic [31:0] fwd_operand(input logic [4:0] idx,
                                                input logic [31:0] rf_data);
        logic [31:0] val;
        if (idx == REG_ZERO) begin
            val = '0;
        end else if (r_s2_valid && r_s2.wr && r_s2.widx == idx) begin
            val = r_s2.wval;
        end else if (r_s3_valid && r_s3.wr && r_s3.widx == idx) begin
            val = r_s3.wval;
        end else if (r_s4_valid && r_s4.wr && r_s4.widx == idx) begin
            val = s4_wval;
        end else if (r_wb_valid && r_wb_idx == idx) begin
            val = r_wb_val;
        end else begin
            val = rf_data;
        end
        return val;
    endfunction

    always_comb begin
        op_a = fwd_operand(s1_rs, rf_a);
        op_b = fwd_operand(s1_rt, rf_b);
    end

    mite_alu u_alu (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_exec  (s1_exec)
    );

    // Word index modulo DATA_WORDS: quotient by reciprocal, then remainder.
    assign s2_prod = {32'b0, r_s2.maddr[31:2]} * {30'b0, MAGIC};
    assign s2_quot = 30'(s2_prod >> SHIFT);
    assign s3_word = r_s3.maddr[31:2];
    assign s3_rem  = s3_word - 30'(r_s3_quot * 30'(DATA_WORDS));
    assign s3_idx  = s3_rem[IDX_W-1:0];

    assign dm_raddr = adv ? s3_idx : r_s4_idx;

    mite_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (dm_we),
        .i_waddr    (r_s4_idx),
        .i_wdata    (s4_merged),
        .i_raddr    (dm_raddr),
        .o_rdata    (dm_rdata),
        .o_clearing (clearing)
    );

    // Commit stage: load data, byte merge for stores, result beat.
    assign s4_word     = (r_st_valid && r_st_idx == r_s4_idx) ? r_st_word : dm_rdata;
    assign s4_lane     = r_s4.maddr[1:0];
    assign s4_byte     = s4_word[{s4_lane, 3'b000} +: 8];
    assign s4_load_val = r_s4.byte_acc ? {{24{s4_byte[7]}}, s4_byte} : s4_word;
    assign s4_wval     = r_s4.load ? s4_load_val : r_s4.wval;

    always_comb begin
        s4_merged = s4_word;
        if (r_s4.byte_acc) begin
            s4_merged[{s4_lane, 3'b000} +: 8] = r_s4.mdata[7:0];
        end else begin
            s4_merged = r_s4.mdata;
        end
    end

    always_comb begin
        s4_res.next_pc       = r_s4.next_pc;
        s4_res.br_taken      = r_s4.taken;
        s4_res.reg_write     = r_s4.wr;
        s4_res.reg_index     = r_s4.widx;
        s4_res.reg_value     = r_s4.wr ? s4_wval : '0;
        s4_res.mem_write     = r_s4.store;
        s4_res.mem_address   = r_s4.maddr;
        s4_res.mem_data      = r_s4.load ? s4_load_val : r_s4.mdata;
        s4_res.byte_access   = r_s4.byte_acc;
        s4_res.unimplemented = r_s4.unimpl;
    end

    assign rf_wr.en   = commit && r_s4.wr;
    assign rf_wr.idx  = r_s4.widx;
    assign rf_wr.data = s4_wval;
    assign dm_we      = commit && r_s4.store;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_pc       <= '0;
            r_wb_valid <= 1'b0;
            r_st_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid <= in_accept || (r_s1_valid && hz);
                r_s2_valid <= r_s1_valid && !hz;
                r_s3_valid <= r_s2_valid;
                r_s4_valid <= r_s3_valid;
            end
            if (i_cfg_valid) begin
                r_pc <= i_cfg_data;
            end else if (adv && r_s1_valid && !hz) begin
                r_pc <= s1_exec.next_pc;
            end
            r_wb_valid <= rf_wr.en;
            r_st_valid <= dm_we;
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_instr <= i_instruction;
        end
        if (adv && r_s1_valid && !hz) begin
            r_s2 <= s1_exec;
        end
        if (adv) begin
            r_s3      <= r_s2;
            r_s3_quot <= s2_quot;
            r_s4      <= r_s3;
            r_s4_idx  <= s3_idx;
        end
        r_wb_idx  <= rf_wr.idx;
        r_wb_val  <= rf_wr.data;
        r_st_idx  <= r_s4_idx;
        r_st_word <= s4_merged;
    end

    // Output buffer: the skid entry fills only when the output beat is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (commit) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (commit) begin
            if (!r_out_valid || pop) begin
                r_out <= s4_res;
            end else begin
                r_skid <= s4_res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_next_pc       = r_out.next_pc;
    assign o_br_taken      = r_out.br_taken;
    assign o_reg_write     = r_out.reg_write;
    assign o_reg_index     = r_out.reg_index;
    assign o_reg_value     = r_out.reg_value;
    assign o_mem_write     = r_out.mem_write;
    assign o_mem_address   = r_out.mem_address;
    assign o_mem_data      = r_out.mem_data;
    assign o_byte_access   = r_out.byte_access;
    assign o_unimplemented = r_out.unimplemented;

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// Self-checking testbench for the I-type execute block, with its own architectural predictor.
module tb_top;
    import mite_pkg::*;

    localparam int MEM_WORDS   = DATA_WORDS_DEFAULT;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;
    localparam int QUIET_LIMIT = 5000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 16;

    // Opcodes and branch codes the block leaves unimplemented.
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [4:0] RT_BAD     = 5'd2;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic [31:0] i_cfg_data    = '0;
    logic        i_in_valid    = 1'b0;
    logic [31:0] i_instruction = '0;
    logic        i_out_ready   = 1'b0;

    logic        o_cfg_ready;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_next_pc;
    logic        o_br_taken;
    logic        o_reg_write;
    logic [4:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_mem_write;
    logic [31:0] o_mem_address;
    logic [31:0] o_mem_data;
    logic        o_byte_access;
    logic        o_unimplemented;

    // Architectural state as the instruction stream sees it.
    logic [31:0] arch_gpr [32];
    logic [31:0] arch_mem [MEM_WORDS];
    logic [31:0] arch_pc;

    logic [31:0] fetch_q [$];
    t_result     retire_q [$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int beats_seen    = 0;
    int quiet_cycles  = 0;

    mips_itype_execute #(
        .DATA_WORDS(MEM_WORDS)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_instruction  (i_instruction),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_next_pc      (o_next_pc),
        .o_br_taken     (o_br_taken),
        .o_reg_write    (o_reg_write),
        .o_reg_index    (o_reg_index),
        .o_reg_value    (o_reg_value),
        .o_mem_write    (o_mem_write),
        .o_mem_address  (o_mem_address),
        .o_mem_data     (o_mem_data),
        .o_byte_access  (o_byte_access),
        .o_unimplemented(o_unimplemented)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs,
                                          input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Executes one instruction on the architectural state and queues the beat it must produce.
    task automatic retire_instruction(input logic [31:0] ins);
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [15:0] imm;
        logic [31:0] sext;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc;
        logic [31:0] maddr;
        logic [31:0] word;
        logic [7:0]  lane_byte;
        logic        link;
        logic        unimpl;
        int unsigned wi;
        int unsigned sh;
        t_result     r;
        op     = ins[31:26];
        rs     = ins[25:21];
        rt     = ins[20:16];
        imm    = ins[15:0];
        sext   = {{16{imm[15]}}, imm};
        a      = arch_gpr[rs];
        b      = arch_gpr[rt];
        pc     = arch_pc;
        maddr  = a + sext;
        wi     = (maddr >> 2) % MEM_WORDS;
        sh     = 8 * maddr[1:0];
        word   = arch_mem[wi];
        link   = 1'b0;
        unimpl = 1'b0;
        r      = '0;
        r.next_pc   = pc + 32'd4;
        r.reg_index = rt;
        case (op)
            OP_REGIMM: begin
                if (rt == RT_BLTZ || rt == RT_BLTZAL) begin
                    r.br_taken = a[31];
                end else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin
                    r.br_taken = !a[31];
                end else begin
                    unimpl = 1'b1;
                end
                link = (rt == RT_BLTZAL || rt == RT_BGEZAL);
            end
            OP_BEQ:  r.br_taken = (a == b);
            OP_BNE:  r.br_taken = (a != b);
            OP_BLEZ: r.br_taken = a[31] || (a == '0);
            OP_BGTZ: r.br_taken = !a[31] && (a != '0);
            OP_ADDI, OP_ADDI_U: begin
                r.reg_write = 1'b1;
                r.reg_value = a + sext;
            end
            OP_SLTI: begin
                r.reg_write = 1'b1;
                r.reg_value = {31'b0, $signed(a) < $signed(sext)};
            end
            OP_SLTI_U: begin
                r.reg_write = 1'b1;
                r.reg_value = {31'b0, a < sext};
            end
            OP_ANDI: begin
                r.reg_write = 1'b1;
                r.reg_value = a & {16'h0, imm};
            end
            OP_ORI: begin
                r.reg_write = 1'b1;
                r.reg_value = a | {16'h0, imm};
            end
            OP_XORI: begin
                r.reg_write = 1'b1;
                r.reg_value = a ^ {16'h0, imm};
            end
            OP_LUI: begin
                r.reg_write = 1'b1;
                r.reg_value = {imm, 16'h0};
            end
            OP_LB: begin
                lane_byte     = 8'(word >> sh);
                r.reg_write   = 1'b1;
                r.reg_value   = {{24{lane_byte[7]}}, lane_byte};
                r.mem_address = maddr;
                r.mem_data    = r.reg_value;
                r.byte_access = 1'b1;
            end
            OP_LW: begin
                r.reg_write   = 1'b1;
                r.reg_value   = word;
                r.mem_address = maddr;
                r.mem_data    = word;
            end
            OP_SB: begin
                arch_mem[wi]  = (word & ~(32'hFF << sh)) | ({24'h0, b[7:0]} << sh);
                r.mem_write   = 1'b1;
                r.mem_address = maddr;
                r.mem_data    = {24'h0, b[7:0]};
                r.byte_access = 1'b1;
            end
            OP_SW: begin
                arch_mem[wi]  = b;
                r.mem_write   = 1'b1;
                r.mem_address = maddr;
                r.mem_data    = b;
            end
            default: unimpl = 1'b1;
        endcase

        if (unimpl) begin
            r               = '0;
            r.next_pc       = pc;
            r.unimplemented = 1'b1;
        end else begin
            if (r.br_taken) begin
                r.next_pc = pc + 32'd4 + (sext << 2);
                if (link) begin
                    r.reg_write = 1'b1;
                    r.reg_index = REG_LINK;
                    r.reg_value = pc + 32'd8;
                end
            end
            if (r.reg_index == REG_ZERO) begin
                r.reg_write = 1'b0;
            end
            if (!r.reg_write) begin
                r.reg_index = REG_ZERO;
                r.reg_value = '0;
            end else begin
                arch_gpr[r.reg_index] = r.reg_value;
            end
            arch_pc = r.next_pc;
        end
        retire_q.push_back(r);
    endtask

    function automatic logic [31:0] random_instruction();
        logic [31:0] ins;
        logic [5:0]  op;
        ins = $urandom();
        // A few raw words keep unsupported opcodes and odd REGIMM codes in the mix.
        if ($urandom_range(99) >= 8) begin
            case ($urandom_range(19))
                0:       op = OP_REGIMM;
                1:       op = OP_BEQ;
                2:       op = OP_BNE;
                3:       op = OP_BLEZ;
                4:       op = OP_BGTZ;
                5:       op = OP_ADDI;
                6:       op = OP_ADDI_U;
                7:       op = OP_SLTI;
                8:       op = OP_SLTI_U;
                9:       op = OP_ANDI;
                10:      op = OP_ORI;
                11:      op = OP_XORI;
                12:      op = OP_LUI;
                13:      op = OP_LB;
                14:      op = OP_LW;
                15:      op = OP_SB;
                16:      op = OP_SW;
                17:      op = OP_LB;
                18:      op = OP_LW;
                default: op = OP_SB;
            endcase
            ins[31:26] = op;
            if (op == OP_REGIMM && $urandom_range(9) != 0) begin
                case ($urandom_range(3))
                    0:       ins[20:16] = RT_BLTZ;
                    1:       ins[20:16] = RT_BGEZ;
                    2:       ins[20:16] = RT_BLTZAL;
                    default: ins[20:16] = RT_BGEZAL;
                endcase
            end
            if ((op == OP_BEQ || op == OP_BNE) && $urandom_range(3) == 0) begin
                ins[20:16] = ins[25:21];
            end
            // Most memory accesses land in a small window so loads see earlier stores.
            if ((op == OP_LB || op == OP_LW || op == OP_SB || op == OP_SW)
                    && $urandom_range(9) < 7) begin
                ins[25:21] = REG_ZERO;
                ins[15:0]  = 16'($urandom_range(255));
            end
        end
        return ins;
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        if (mismatches < MAX_REPORTS) begin
            $display("result beat %0d: %s expected %h, got %h", beats_seen, what, exp_v, act_v);
        end
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            note_mismatch(what, exp_v, act_v);
        end
    endtask

    // Instruction sender.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                retire_instruction(i_instruction);
            end
            if (!i_in_valid || o_in_ready) begin
                if (fetch_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid    <= 1'b1;
                    i_instruction <= fetch_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver and checker.
    always @(posedge i_clk) begin : result_check
        t_result exp_r;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (retire_q.size() == 0) begin
                    note_mismatch("unexpected beat, next_pc", '0, o_next_pc);
                end else begin
                    exp_r = retire_q.pop_front();
                    check_field("next_pc", exp_r.next_pc, o_next_pc);
                    check_field("br_taken", exp_r.br_taken, o_br_taken);
                    check_field("reg_write", exp_r.reg_write, o_reg_write);
                    check_field("reg_index", exp_r.reg_index, o_reg_index);
                    check_field("reg_value", exp_r.reg_value, o_reg_value);
                    check_field("mem_write", exp_r.mem_write, o_mem_write);
                    check_field("mem_address", exp_r.mem_address, o_mem_address);
                    check_field("mem_data", exp_r.mem_data, o_mem_data);
                    check_field("byte_access", exp_r.byte_access, o_byte_access);
                    check_field("unimplemented", exp_r.unimplemented, o_unimplemented);
                end
                beats_seen++;
            end
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on cycles in which no channel moves a beat.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reset_pc(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        arch_pc      = value;
    endtask

    // Returns at a falling edge once nothing is queued, offered or awaited.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (fetch_q.size() != 0 || i_in_valid || retire_q.size() != 0);
    endtask

    initial begin
        int          ph;
        logic [31:0] pc_value;
        for (int i = 0; i < 32; i++) begin
            arch_gpr[i] = '0;
        end
        for (int i = 0; i < MEM_WORDS; i++) begin
            arch_mem[i] = '0;
        end
        arch_pc      = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, run from the reset value of the pc.
        fetch_q.push_back(itype(OP_LUI,    5'd0, 5'd1, 16'h7FFF));
        fetch_q.push_back(itype(OP_ORI,    5'd1, 5'd1, 16'hFFFF));
        fetch_q.push_back(itype(OP_ADDI,   5'd1, 5'd2, 16'h0001));   // wraps to the most negative
        fetch_q.push_back(itype(OP_ADDI_U, 5'd0, 5'd3, 16'hFFFF));
        fetch_q.push_back(itype(OP_SLTI,   5'd2, 5'd4, 16'h8000));
        fetch_q.push_back(itype(OP_SLTI_U, 5'd3, 5'd5, 16'hFFFF));
        fetch_q.push_back(itype(OP_ANDI,   5'd3, 5'd6, 16'h8001));
        fetch_q.push_back(itype(OP_XORI,   5'd3, 5'd7, 16'hFFFF));
        fetch_q.push_back(itype(OP_ADDI,   5'd3, 5'd0, 16'h0005));   // write to the zero register
        fetch_q.push_back(itype(OP_SW,     5'd0, 5'd1, 16'h0003));   // low address bits ignored
        fetch_q.push_back(itype(OP_SB,     5'd0, 5'd4, 16'h0001));
        fetch_q.push_back(itype(OP_LB,     5'd0, 5'd8, 16'h0003));
        fetch_q.push_back(itype(OP_LB,     5'd0, 5'd8, 16'h0000));
        fetch_q.push_back(itype(OP_LW,     5'd0, 5'd9, 16'h1000));   // word index wraps
        fetch_q.push_back(itype(OP_LW,     5'd3, 5'd0, 16'h0001));   // load into the zero register
        fetch_q.push_back(itype(OP_BEQ,    5'd0, 5'd0, 16'h7FFF));
        fetch_q.push_back(itype(OP_BNE,    5'd1, 5'd2, 16'h8000));
        fetch_q.push_back(itype(OP_BLEZ,   5'd0, 5'd0, 16'h0001));
        fetch_q.push_back(itype(OP_BGTZ,   5'd2, 5'd0, 16'h0010));
        fetch_q.push_back(itype(OP_REGIMM, 5'd2, RT_BLTZ,   16'hFFFE));
        fetch_q.push_back(itype(OP_REGIMM, 5'd2, RT_BGEZ,   16'h0004));
        fetch_q.push_back(itype(OP_REGIMM, 5'd0, RT_BLTZAL, 16'h0004));
        fetch_q.push_back(itype(OP_REGIMM, 5'd0, RT_BGEZAL, 16'h0020));
        fetch_q.push_back(itype(OP_REGIMM, 5'd31, RT_BGEZAL, 16'hFFF0));
        fetch_q.push_back(itype(OP_REGIMM, 5'd1, RT_BAD,    16'h1234));
        fetch_q.push_back(itype(OP_J,      5'd31, 5'd31,    16'hFFFF));
        fetch_q.push_back(itype(OP_SPECIAL, 5'd1, 5'd2,     16'h0020));
        fetch_q.push_back(itype(OP_COP0,   5'd0, 5'd0,      16'h0000));
        wait_drained();

        // Each phase starts from an empty pipeline, so the sender has waited out every result.
        for (ph = 1; ph <= PHASES; ph++) begin
            case (ph)
                1:       pc_value = 32'hFFFF_FFFC;
                2:       pc_value = 32'h0000_0000;
                3:       pc_value = 32'hFFFF_FFFF;
                4:       pc_value = 32'h8000_0000;
                5:       pc_value = 32'h0040_0000;
                default: pc_value = $urandom();
            endcase
            write_reset_pc(pc_value);
            @(negedge i_clk);
            send_idle_pct = (ph % 4 == 1) ? 49 : (ph % 4 == 3) ? 6 : 0;
            stall_pct     = (ph % 4 == 2) ? 49 : (ph % 4 == 3) ? 6 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                fetch_q.push_back(random_instruction());
            end
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0 && retire_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- mips_itype_execute.f -----
src/mite_pkg.sv
src/mite_regfile.sv
src/mite_dmem.sv
src/mite_alu.sv
src/mips_itype_execute.sv
verif/tb_top.sv
